[rtl/core/ldra_pkg.sv]
// ============================================================================
// ldra_pkg
// Shared types, constants and arithmetic helpers of the lens remap address
// generator.
// ============================================================================
package ldra_pkg;

    localparam int ImageWidthDef  = 256;
    localparam int ImageHeightDef = 256;

    // Fraction bits of the normalized Q4.28 values
    localparam int Frac = 28;

    // Quotient bits resolved per divider stage
    localparam int DivSteps = 4;

    typedef enum logic [2:0] {
        REG_FOCAL_X  = 3'd0,
        REG_FOCAL_Y  = 3'd1,
        REG_CENTRE_X = 3'd2,
        REG_CENTRE_Y = 3'd3,
        REG_K1       = 3'd4,
        REG_K2       = 3'd5,
        REG_P1       = 3'd6,
        REG_P2       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic        [23:0] focal_x;
        logic        [23:0] focal_y;
        logic        [23:0] centre_x;
        logic        [23:0] centre_y;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] xn;
        logic signed [31:0] yn;
    } t_norm;

    typedef struct packed {
        logic signed [31:0] xd;
        logic signed [31:0] yd;
    } t_dist;

    typedef struct packed {
        logic signed [11:0] src_col;
        logic signed [11:0] src_row;
        logic        [15:0] src_address;
        logic               out_of_range;
    } t_res;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = $signed(v[31:0]);
        end
        return r;
    endfunction

    // Q4.28 product back to Q4.28, rounding toward minus infinity
    function automatic logic signed [35:0] qsh(input logic signed [63:0] p);
        return $signed(p[63:Frac]);
    endfunction

    // One restoring division step: returns {quotient bit, new remainder}
    function automatic logic [24:0] div_step(input logic [23:0] rem, input logic nbit,
                                             input logic [23:0] f);
        logic [24:0] t;
        logic [24:0] d;
        t = {rem, nbit};
        d = t - {1'b0, f};
        if (t >= {1'b0, f}) begin
            return {1'b1, d[23:0]};
        end
        return {1'b0, t[23:0]};
    endfunction

endpackage

[rtl/core/ldra_if.sv]
// ============================================================================
// ldra_if
// Valid/ready channels for destination coordinates and source addresses.
// ============================================================================
interface ldra_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] dest_col;
    logic [7:0] dest_row;

    modport source (output valid, dest_col, dest_row, input ready);
    modport sink   (input valid, dest_col, dest_row, output ready);
endinterface

interface ldra_out_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] src_col;
    logic signed [11:0] src_row;
    logic        [15:0] src_address;
    logic               out_of_range;

    modport source (output valid, src_col, src_row, src_address, out_of_range, input ready);
    modport sink   (input valid, src_col, src_row, src_address, out_of_range, output ready);
endinterface

[rtl/core/ldra_regs.sv]
// ============================================================================
// ldra_regs
// APB register file holding the lens calibration.
// ============================================================================
module ldra_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ldra_pkg::t_cfg    o_cfg
);

    ldra_pkg::t_cfg   r_cfg;
    ldra_pkg::t_reg_idx idx;
    logic             wr;

    assign idx    = ldra_pkg::t_reg_idx'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x  <= 24'd585691;
            r_cfg.focal_y  <= 24'd531382;
            r_cfg.centre_x <= 24'd385036;
            r_cfg.centre_y <= 24'd242569;
            r_cfg.k1       <= -32'sd109081700;
            r_cfg.k2       <= 32'sd45220905;
            r_cfg.p1       <= 32'sd248571;
            r_cfg.p2       <= -32'sd60666;
        end else if (wr) begin
            unique case (idx)
                ldra_pkg::REG_FOCAL_X:  r_cfg.focal_x  <= pwdata[23:0];
                ldra_pkg::REG_FOCAL_Y:  r_cfg.focal_y  <= pwdata[23:0];
                ldra_pkg::REG_CENTRE_X: r_cfg.centre_x <= pwdata[23:0];
                ldra_pkg::REG_CENTRE_Y: r_cfg.centre_y <= pwdata[23:0];
                ldra_pkg::REG_K1:       r_cfg.k1       <= $signed(pwdata);
                ldra_pkg::REG_K2:       r_cfg.k2       <= $signed(pwdata);
                ldra_pkg::REG_P1:       r_cfg.p1       <= $signed(pwdata);
                ldra_pkg::REG_P2:       r_cfg.p2       <= $signed(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            ldra_pkg::REG_FOCAL_X:  prdata = {8'd0, r_cfg.focal_x};
            ldra_pkg::REG_FOCAL_Y:  prdata = {8'd0, r_cfg.focal_y};
            ldra_pkg::REG_CENTRE_X: prdata = {8'd0, r_cfg.centre_x};
            ldra_pkg::REG_CENTRE_Y: prdata = {8'd0, r_cfg.centre_y};
            ldra_pkg::REG_K1:       prdata = r_cfg.k1;
            ldra_pkg::REG_K2:       prdata = r_cfg.k2;
            ldra_pkg::REG_P1:       prdata = r_cfg.p1;
            ldra_pkg::REG_P2:       prdata = r_cfg.p2;
            default:                prdata = 32'd0;
        endcase
    end

    // a completed write lands in the addressed register
    a_k1_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr && idx == ldra_pkg::REG_K1 |=> r_cfg.k1 == $signed($past(pwdata)))
        else $error("k1 write lost");

endmodule

[rtl/core/ldra_norm.sv]
// ============================================================================
// ldra_norm
// Normalization: (pixel*4096 - centre) * 2^28 / focal, pipelined restoring
// divider for both axes, quotient saturated to 32 bits.
// ============================================================================
module ldra_norm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_col,
    input  logic [7:0]        i_row,
    input  ldra_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output ldra_pkg::t_norm   o_norm
);

    localparam int NumDiv = 32 / ldra_pkg::DivSteps;
    localparam int NumStg = NumDiv + 2;

    logic [NumStg-1:0] r_v;
    logic [NumStg:0]   en;

    // divider state per stage (index 0 is the prepared operand) and axis
    logic [23:0] r_rem  [NumDiv+1][2];
    logic [31:0] r_q    [NumDiv+1][2];
    logic        r_neg  [NumDiv+1][2];
    logic        r_ovf  [NumDiv+1][2];
    logic [3:0]  r_nlow [NumDiv+1][2];
    logic [23:0] r_f    [NumDiv+1][2];

    logic [23:0] n_rem  [2];
    logic        n_neg  [2];
    logic        n_ovf  [2];
    logic [3:0]  n_nlow [2];
    logic [23:0] n_f    [2];

    logic signed [31:0] r_res [2];
    logic signed [31:0] n_res [2];

    // bubble-collapsing stall chain
    assign en[NumStg] = i_ready;
    for (genvar k = 0; k < NumStg; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end
    assign o_ready = en[0];
    assign o_valid = r_v[NumStg-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NumStg; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // operand preparation
    always_comb begin
        logic        [7:0]  pix;
        logic        [23:0] cen;
        logic        [23:0] foc;
        logic signed [24:0] d;
        logic        [24:0] mag;
        for (int a = 0; a < 2; a++) begin
            pix = (a == 1) ? i_row : i_col;
            cen = (a == 1) ? i_cfg.centre_y : i_cfg.centre_x;
            foc = (a == 1) ? i_cfg.focal_y : i_cfg.focal_x;
            n_f[a]    = (foc == 24'd0) ? 24'd1 : foc;
            d         = $signed({5'd0, pix, 12'd0}) - $signed({1'b0, cen});
            mag       = d[24] ? 25'(-d) : 25'(d);
            n_neg[a]  = d[24];
            n_ovf[a]  = {4'd0, mag[23:0]} >= {n_f[a], 4'd0};
            n_rem[a]  = {4'd0, mag[23:4]};
            n_nlow[a] = mag[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int a = 0; a < 2; a++) begin
                r_rem[0][a]  <= n_rem[a];
                r_q[0][a]    <= 32'd0;
                r_neg[0][a]  <= n_neg[a];
                r_ovf[0][a]  <= n_ovf[a];
                r_nlow[0][a] <= n_nlow[a];
                r_f[0][a]    <= n_f[a];
            end
        end
    end

    for (genvar k = 1; k <= NumDiv; k++) begin : g_div
        logic [23:0] s_rem [2];
        logic [31:0] s_q   [2];

        always_comb begin
            logic [31:0] nb;
            logic [24:0] st;
            for (int a = 0; a < 2; a++) begin
                nb       = {r_nlow[k-1][a], 28'd0};
                s_rem[a] = r_rem[k-1][a];
                s_q[a]   = r_q[k-1][a];
                for (int j = 0; j < ldra_pkg::DivSteps; j++) begin
                    st = ldra_pkg::div_step(s_rem[a],
                        nb[31 - (k-1)*ldra_pkg::DivSteps - j], r_f[k-1][a]);
                    s_rem[a] = st[23:0];
                    s_q[a]   = {s_q[a][30:0], st[24]};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                for (int a = 0; a < 2; a++) begin
                    r_rem[k][a]  <= s_rem[a];
                    r_q[k][a]    <= s_q[a];
                    r_neg[k][a]  <= r_neg[k-1][a];
                    r_ovf[k][a]  <= r_ovf[k-1][a];
                    r_nlow[k][a] <= r_nlow[k-1][a];
                    r_f[k][a]    <= r_f[k-1][a];
                end
            end
        end
    end

    // sign and saturate
    always_comb begin
        logic [31:0] q;
        for (int a = 0; a < 2; a++) begin
            q = r_q[NumDiv][a];
            if (!r_neg[NumDiv][a]) begin
                n_res[a] = (r_ovf[NumDiv][a] || q[31]) ? 32'sh7FFF_FFFF : $signed(q);
            end else if (r_ovf[NumDiv][a] || (q[31] && (q[30:0] != 31'd0))) begin
                n_res[a] = 32'sh8000_0000;
            end else begin
                n_res[a] = $signed(32'd0 - q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NumStg-1]) begin
            r_res[0] <= n_res[0];
            r_res[1] <= n_res[1];
        end
    end

    assign o_norm.xn = r_res[0];
    assign o_norm.yn = r_res[1];

    // without overflow the first partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && !r_ovf[0][0] |-> r_rem[0][0] < r_f[0][0])
        else $error("divider remainder out of bound");

endmodule

[rtl/core/ldra_poly.sv]
// ============================================================================
// ldra_poly
// Radial and tangential distortion of a normalized coordinate, Q4.28.
// ============================================================================
module ldra_poly (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ldra_pkg::t_norm   i_norm,
    input  ldra_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output ldra_pkg::t_dist   o_dist
);

    localparam int NumStg = 8;
    localparam logic signed [63:0] OneQ = 64'sd1 <<< ldra_pkg::Frac;

    logic [NumStg-1:0] r_v;
    logic [NumStg:0]   en;

    assign en[NumStg] = i_ready;
    for (genvar k = 0; k < NumStg; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end
    assign o_ready = en[0];
    assign o_valid = r_v[NumStg-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NumStg; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // coordinates carried along the pipe
    logic signed [31:0] r_xn [NumStg-1];
    logic signed [31:0] r_yn [NumStg-1];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_xn[0] <= i_norm.xn;
            r_yn[0] <= i_norm.yn;
        end
        for (int k = 1; k < NumStg - 1; k++) begin
            if (en[k]) begin
                r_xn[k] <= r_xn[k-1];
                r_yn[k] <= r_yn[k-1];
            end
        end
    end

    // stage 0: squares and cross product
    logic signed [63:0] r0_pxx, r0_pyy, r0_pxy;
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_pxx <= i_norm.xn * i_norm.xn;
            r0_pyy <= i_norm.yn * i_norm.yn;
            r0_pxy <= i_norm.xn * i_norm.yn;
        end
    end

    // stage 1: r2 and tangential sums
    logic signed [31:0] n1_xx, n1_yy, n1_r2;
    logic signed [31:0] r1_xy, r1_r2, r1_tx, r1_ty;
    always_comb begin
        n1_xx = ldra_pkg::sat32(64'(ldra_pkg::qsh(r0_pxx)));
        n1_yy = ldra_pkg::sat32(64'(ldra_pkg::qsh(r0_pyy)));
        n1_r2 = ldra_pkg::sat32(64'(n1_xx) + 64'(n1_yy));
    end
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_xy <= ldra_pkg::sat32(64'(ldra_pkg::qsh(r0_pxy)));
            r1_r2 <= n1_r2;
            r1_tx <= ldra_pkg::sat32(64'(n1_r2) + (64'(n1_xx) <<< 1));
            r1_ty <= ldra_pkg::sat32(64'(n1_r2) + (64'(n1_yy) <<< 1));
        end
    end

    // stage 2: coefficient products
    logic signed [63:0] r2_pr4, r2_pk1, r2_p1xy, r2_p2tx, r2_p1ty, r2_p2xy;
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_pr4  <= r1_r2 * r1_r2;
            r2_pk1  <= i_cfg.k1 * r1_r2;
            r2_p1xy <= i_cfg.p1 * r1_xy;
            r2_p2tx <= i_cfg.p2 * r1_tx;
            r2_p1ty <= i_cfg.p1 * r1_ty;
            r2_p2xy <= i_cfg.p2 * r1_xy;
        end
    end

    // stage 3: r4, k1 term, tangential terms
    logic signed [31:0] r3_r4;
    logic signed [35:0] r3_t1;
    logic signed [37:0] r3_gx, r3_gy;
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_r4 <= ldra_pkg::sat32(64'(ldra_pkg::qsh(r2_pr4)));
            r3_t1 <= ldra_pkg::qsh(r2_pk1);
            r3_gx <= (38'(ldra_pkg::qsh(r2_p1xy)) <<< 1) + 38'(ldra_pkg::qsh(r2_p2tx));
            r3_gy <= 38'(ldra_pkg::qsh(r2_p1ty)) + (38'(ldra_pkg::qsh(r2_p2xy)) <<< 1);
        end
    end

    // stage 4: k2 product
    logic signed [63:0] r4_pk2;
    logic signed [35:0] r4_t1;
    logic signed [37:0] r4_gx, r4_gy;
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_pk2 <= i_cfg.k2 * r3_r4;
            r4_t1  <= r3_t1;
            r4_gx  <= r3_gx;
            r4_gy  <= r3_gy;
        end
    end

    // stage 5: radial factor
    logic signed [31:0] r5_rad;
    logic signed [37:0] r5_gx, r5_gy;
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_rad <= ldra_pkg::sat32(OneQ + 64'(r4_t1) + 64'(ldra_pkg::qsh(r4_pk2)));
            r5_gx  <= r4_gx;
            r5_gy  <= r4_gy;
        end
    end

    // stage 6: radial scaling
    logic signed [63:0] r6_prx, r6_pry;
    logic signed [37:0] r6_gx, r6_gy;
    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_prx <= r5_rad * r_xn[5];
            r6_pry <= r5_rad * r_yn[5];
            r6_gx  <= r5_gx;
            r6_gy  <= r5_gy;
        end
    end

    // stage 7: distorted coordinate
    logic signed [31:0] r7_xd, r7_yd;
    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_xd <= ldra_pkg::sat32(64'(ldra_pkg::qsh(r6_prx)) + 64'(r6_gx));
            r7_yd <= ldra_pkg::sat32(64'(ldra_pkg::qsh(r6_pry)) + 64'(r6_gy));
        end
    end

    assign o_dist.xd = r7_xd;
    assign o_dist.yd = r7_yd;

    // r2 is a sum of squares and never negative
    a_r2_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> !r1_r2[31])
        else $error("negative r2");

endmodule

[rtl/core/ldra_denorm.sv]
// ============================================================================
// ldra_denorm
// Back to pixels, range check, clamp and flat address.
// ============================================================================
module ldra_denorm #(
    parameter int IMAGE_WIDTH  = ldra_pkg::ImageWidthDef,
    parameter int IMAGE_HEIGHT = ldra_pkg::ImageHeightDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ldra_pkg::t_dist   i_dist,
    input  ldra_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output ldra_pkg::t_res    o_res
);

    localparam int NumStg = 3;
    localparam logic signed [17:0] WLim = 18'(IMAGE_WIDTH);
    localparam logic signed [17:0] HLim = 18'(IMAGE_HEIGHT);
    localparam logic        [12:0] WMul = 13'(IMAGE_WIDTH);

    logic [NumStg-1:0] r_v;
    logic [NumStg:0]   en;

    assign en[NumStg] = i_ready;
    for (genvar k = 0; k < NumStg; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end
    assign o_ready = en[0];
    assign o_valid = r_v[NumStg-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NumStg; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: focal * d
    logic signed [56:0] r0_mx, r0_my;
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_mx <= $signed({1'b0, i_cfg.focal_x}) * i_dist.xd;
            r0_my <= $signed({1'b0, i_cfg.focal_y}) * i_dist.yd;
        end
    end

    // stage 1: add centre, truncate toward zero
    function automatic logic signed [17:0] to_pix(input logic signed [56:0] m,
                                                  input logic [23:0] c);
        logic signed [57:0] v;
        logic        [57:0] mag;
        logic        [17:0] p;
        v   = 58'(m) + $signed({6'd0, c, 28'd0});
        mag = v[57] ? 58'(-v) : 58'(v);
        p   = mag[57:40];
        return v[57] ? $signed(18'd0 - p) : $signed(p);
    endfunction

    logic signed [17:0] r1_col, r1_row;
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_col <= to_pix(r0_mx, i_cfg.centre_x);
            r1_row <= to_pix(r0_my, i_cfg.centre_y);
        end
    end

    // stage 2: range check, clamp, address
    function automatic logic signed [11:0] clamp12(input logic signed [17:0] v);
        if (v > 18'sd2047) begin
            return 12'sd2047;
        end
        if (v < -18'sd2048) begin
            return -12'sd2048;
        end
        return $signed(v[11:0]);
    endfunction

    logic        n_oor;
    logic [24:0] n_addr;
    always_comb begin
        n_oor  = r1_col[17] || (r1_col >= WLim) || r1_row[17] || (r1_row >= HLim);
        n_addr = 25'(r1_row[11:0]) * 25'(WMul) + 25'(r1_col[11:0]);
    end

    ldra_pkg::t_res r2_res;
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_res.src_col      <= clamp12(r1_col);
            r2_res.src_row      <= clamp12(r1_row);
            r2_res.out_of_range <= n_oor;
            r2_res.src_address  <= n_oor ? 16'd0 : n_addr[15:0];
        end
    end

    assign o_res = r2_res;

endmodule

[rtl/core/lens_distortion_remap_address_top.sv]
// ============================================================================
// lens_distortion_remap_address_top
// Brown-Conrady remap address generator: destination pixel in, source
// column, row, flat address and range flag out.
// ============================================================================
//  channel  | direction | handshake          | payload
//  i_dest   | in        | valid/ready        | dest_col, dest_row
//  o_src    | out       | valid/ready        | src_col, src_row, src_address,
//           |           |                    | out_of_range
//  APB      | in        | psel/penable/pready| 8 registers at 4*i
//
//  One transaction per cycle sustained while o_src is ready; 10 normalize,
//  8 distortion and 3 denormalize stages, the normalize divider stages resolving
//  the 32 quotient bits 4 per stage. Synchronous active-low reset clears all valid bits and loads
//  the default calibration. A stall at o_src fills bubbles first, then holds
//  every stage; nothing is dropped or repeated.
// ============================================================================
module lens_distortion_remap_address_top #(
    parameter int IMAGE_WIDTH  = ldra_pkg::ImageWidthDef,
    parameter int IMAGE_HEIGHT = ldra_pkg::ImageHeightDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ldra_in_if.sink           i_dest,
    ldra_out_if.source        o_src,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    ldra_pkg::t_cfg  cfg;
    ldra_pkg::t_norm norm;
    ldra_pkg::t_dist distort;
    ldra_pkg::t_res  res;
    logic            norm_valid, norm_ready;
    logic            dist_valid, dist_ready;

    ldra_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ldra_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_dest.valid),
        .o_ready (i_dest.ready),
        .i_col   (i_dest.dest_col),
        .i_row   (i_dest.dest_row),
        .i_cfg   (cfg),
        .o_valid (norm_valid),
        .i_ready (norm_ready),
        .o_norm  (norm)
    );

    ldra_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (norm_valid),
        .o_ready (norm_ready),
        .i_norm  (norm),
        .i_cfg   (cfg),
        .o_valid (dist_valid),
        .i_ready (dist_ready),
        .o_dist  (distort)
    );

    ldra_denorm #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_denorm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dist_valid),
        .o_ready (dist_ready),
        .i_dist  (distort),
        .i_cfg   (cfg),
        .o_valid (o_src.valid),
        .i_ready (o_src.ready),
        .o_res   (res)
    );

    assign o_src.src_col      = res.src_col;
    assign o_src.src_row      = res.src_row;
    assign o_src.src_address  = res.src_address;
    assign o_src.out_of_range = res.out_of_range;

    a_oor_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_src.valid && o_src.out_of_range |-> o_src.src_address == 16'd0)
        else $error("address not zero out of range");

    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_src.valid && !o_src.out_of_range |->
            !o_src.src_col[11] && !o_src.src_row[11] &&
            (32'(o_src.src_col) < IMAGE_WIDTH) && (32'(o_src.src_row) < IMAGE_HEIGHT))
        else $error("in-range result outside image");

    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_src.valid && !o_src.out_of_range |->
            o_src.src_address ==
            16'(32'(o_src.src_row) * IMAGE_WIDTH + 32'(o_src.src_col)))
        else $error("flat address mismatch");

endmodule

[dv/tb_lens_distortion_remap_address_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_lens_distortion_remap_address_top
// Drives destination pixels through the remap address generator under
// several calibrations, predicts each source column, row, address and range
// flag in fixed point, and checks every output transaction in order.
// ============================================================================

class remap_scoreboard;
    ldra_pkg::t_cfg   cal;
    ldra_pkg::t_res   pending_src[$];
    int               mismatches;

    function new();
        mismatches = 0;
    endfunction

    function longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint qm(longint a, longint b);
        return (a * b) >>> ldra_pkg::Frac;
    endfunction

    function longint to_norm(longint pix, logic [23:0] ctr, logic [23:0] foc);
        longint f;
        f = (foc == 0) ? 64'sd1 : longint'(foc);
        return sat(((pix * 4096 - longint'(ctr)) * (64'sd1 <<< ldra_pkg::Frac)) / f);
    endfunction

    function longint to_pixel(logic [23:0] foc, logic [23:0] ctr, longint d);
        longint v;
        v = longint'(foc) * d + longint'(ctr) * (64'sd1 <<< ldra_pkg::Frac);
        return (v >= 0) ? (v >>> 40) : -((-v) >>> 40);
    endfunction

    function longint clamp12(longint v);
        if (v > 2047) return 2047;
        if (v < -2048) return -2048;
        return v;
    endfunction

    function void note_dest(logic [7:0] col, logic [7:0] row);
        longint xn, yn, xx, yy, xy, r2, r4, rad, tx, ty, xd, yd, c, r, one;
        ldra_pkg::t_res res;
        one = 64'sd1 <<< ldra_pkg::Frac;
        xn  = to_norm(longint'(col), cal.centre_x, cal.focal_x);
        yn  = to_norm(longint'(row), cal.centre_y, cal.focal_y);
        xx  = sat(qm(xn, xn));
        yy  = sat(qm(yn, yn));
        xy  = sat(qm(xn, yn));
        r2  = sat(xx + yy);
        r4  = sat(qm(r2, r2));
        rad = sat(one + qm(longint'(cal.k1), r2) + qm(longint'(cal.k2), r4));
        tx  = sat(r2 + 2 * xx);
        ty  = sat(r2 + 2 * yy);
        xd  = sat(qm(rad, xn) + 2 * qm(longint'(cal.p1), xy) + qm(longint'(cal.p2), tx));
        yd  = sat(qm(rad, yn) + qm(longint'(cal.p1), ty) + 2 * qm(longint'(cal.p2), xy));
        c   = to_pixel(cal.focal_x, cal.centre_x, xd);
        r   = to_pixel(cal.focal_y, cal.centre_y, yd);
        res.out_of_range = (c < 0 || c >= ldra_pkg::ImageWidthDef ||
                            r < 0 || r >= ldra_pkg::ImageHeightDef);
        res.src_address  = res.out_of_range ? 16'd0 :
                           16'((r * ldra_pkg::ImageWidthDef + c) & 16'hFFFF);
        res.src_col      = 12'(clamp12(c));
        res.src_row      = 12'(clamp12(r));
        pending_src.push_back(res);
    endfunction

    function void check_src(ldra_pkg::t_res got);
        ldra_pkg::t_res exp_res;
        if (pending_src.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected source transaction %p", got);
            return;
        end
        exp_res = pending_src.pop_front();
        if (got.src_col !== exp_res.src_col || got.src_row !== exp_res.src_row ||
            got.src_address !== exp_res.src_address ||
            got.out_of_range !== exp_res.out_of_range) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: expected col %0d row %0d addr %0d oor %0b, ",
                          "got col %0d row %0d addr %0d oor %0b"},
                         exp_res.src_col, exp_res.src_row, exp_res.src_address,
                         exp_res.out_of_range, got.src_col, got.src_row,
                         got.src_address, got.out_of_range);
        end
    endfunction
endclass

module tb_lens_distortion_remap_address_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        steady;

    ldra_in_if  dest_ch ();
    ldra_out_if src_ch ();

    remap_scoreboard sb;

    lens_distortion_remap_address_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dest  (dest_ch.sink),
        .o_src   (src_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("lens_distortion_remap_address_top regression: fail");
        $finish;
    end

    // Accepted transactions on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && dest_ch.valid && dest_ch.ready)
            sb.note_dest(dest_ch.dest_col, dest_ch.dest_row);
        if (i_rst_n && src_ch.valid && src_ch.ready)
            sb.check_src('{src_col: src_ch.src_col, src_row: src_ch.src_row,
                           src_address: src_ch.src_address,
                           out_of_range: src_ch.out_of_range});
    end

    always @(posedge i_clk) begin
        src_ch.ready <= steady || ($urandom_range(99) >= 12);
    end

    task automatic cfg_write(ldra_pkg::t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            ldra_pkg::REG_FOCAL_X:  sb.cal.focal_x  = val[23:0];
            ldra_pkg::REG_FOCAL_Y:  sb.cal.focal_y  = val[23:0];
            ldra_pkg::REG_CENTRE_X: sb.cal.centre_x = val[23:0];
            ldra_pkg::REG_CENTRE_Y: sb.cal.centre_y = val[23:0];
            ldra_pkg::REG_K1:       sb.cal.k1       = val;
            ldra_pkg::REG_K2:       sb.cal.k2       = val;
            ldra_pkg::REG_P1:       sb.cal.p1       = val;
            default:                sb.cal.p2       = val;
        endcase
    endtask

    task automatic send_dest(logic [7:0] col, logic [7:0] row);
        if (!steady && $urandom_range(99) < 12) begin
            dest_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        dest_ch.valid    <= 1'b1;
        dest_ch.dest_col <= col;
        dest_ch.dest_row <= row;
        do @(posedge i_clk); while (!dest_ch.ready);
    endtask

    task automatic drain();
        dest_ch.valid <= 1'b0;
        while (sb.pending_src.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Plausible calibration most of the time, register extremes or random values otherwise
    task automatic load_calibration(int mode);
        logic [31:0] kv [4];
        for (int i = 0; i < 4; i++) begin
            case (mode)
                0:       kv[i] = $urandom_range(0, 1) ? $urandom_range(0, 32'h0400_0000)
                                                      : -$urandom_range(0, 32'h0400_0000);
                1:       kv[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: kv[i] = $urandom;
            endcase
        end
        case (mode)
            0: begin
                cfg_write(ldra_pkg::REG_FOCAL_X, $urandom_range(24'h02_0000, 24'h20_0000));
                cfg_write(ldra_pkg::REG_FOCAL_Y, $urandom_range(24'h02_0000, 24'h20_0000));
                cfg_write(ldra_pkg::REG_CENTRE_X, $urandom_range(24'h00_0000, 24'h10_0000));
                cfg_write(ldra_pkg::REG_CENTRE_Y, $urandom_range(24'h00_0000, 24'h10_0000));
            end
            1: begin
                // zero focal length acts as one LSB
                cfg_write(ldra_pkg::REG_FOCAL_X,
                          $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF);
                cfg_write(ldra_pkg::REG_FOCAL_Y,
                          $urandom_range(0, 1) ? 32'h0 : 32'h00FF_FFFF);
                cfg_write(ldra_pkg::REG_CENTRE_X,
                          $urandom_range(0, 1) ? 32'h0 : 32'h00FF_FFFF);
                cfg_write(ldra_pkg::REG_CENTRE_Y,
                          $urandom_range(0, 1) ? 32'h0 : 32'hFF00_0000);
            end
            default: begin
                cfg_write(ldra_pkg::REG_FOCAL_X, $urandom);
                cfg_write(ldra_pkg::REG_FOCAL_Y, $urandom);
                cfg_write(ldra_pkg::REG_CENTRE_X, $urandom);
                cfg_write(ldra_pkg::REG_CENTRE_Y, $urandom);
            end
        endcase
        cfg_write(ldra_pkg::REG_K1, kv[0]);
        cfg_write(ldra_pkg::REG_K2, kv[1]);
        cfg_write(ldra_pkg::REG_P1, kv[2]);
        cfg_write(ldra_pkg::REG_P2, kv[3]);
    endtask

    initial begin
        sb = new();
        sb.cal = '{focal_x: 24'd585691, focal_y: 24'd531382, centre_x: 24'd385036,
                   centre_y: 24'd242569, k1: -32'sd109081700, k2: 32'sd45220905,
                   p1: 32'sd248571, p2: -32'sd60666};
        steady           = 1'b0;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        dest_ch.valid    = 1'b0;
        dest_ch.dest_col = '0;
        dest_ch.dest_row = '0;
        src_ch.ready     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corners, center and single-bit walks with the reset calibration
        send_dest(8'd0, 8'd0);
        send_dest(8'd255, 8'd0);
        send_dest(8'd0, 8'd255);
        send_dest(8'd255, 8'd255);
        send_dest(8'd94, 8'd59);
        for (int b = 0; b < 8; b++) send_dest(8'(1 << b), 8'(8'hFF ^ (1 << b)));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            steady = (ph == 3);
            load_calibration(ph == 1 || ph == 5 ? 1 : (ph == 6 ? 2 : 0));
            send_dest(8'd0, 8'd0);
            send_dest(8'd255, 8'd255);
            repeat (150) send_dest(8'($urandom), 8'($urandom));
            drain();
        end

        if (sb.mismatches == 0) begin
            $display("lens_distortion_remap_address_top regression: pass");
        end else begin
            $display("lens_distortion_remap_address_top regression: fail");
        end
        $finish;
    end
endmodule
